// ----- sv/npm_pkg.sv -----
// Package for the nearest point matcher: widths, action codes, scan states
// and the struct passed from the scan control to the distance pipeline.
// No dependencies.
package npm_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int COORD_BITS  = 24;
    localparam int ADDR_BITS   = $clog2(MAX_POINTS);
    localparam int COUNT_BITS  = 11;
    localparam int INDEX_BITS  = 10;
    localparam int DIST_BITS   = 50;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS     = 2 * DIFF_BITS;
    localparam int SUM_BITS    = SQ_BITS + 2;
    localparam int POINT_BITS  = 3 * COORD_BITS;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [DIST_BITS-1:0] DIST_SAT = {DIST_BITS{1'b1}};

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        CFG_ONE_TO_ONE = 1'b0,
        CFG_REF_COUNT  = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_SCAN  = 3'd1,
        ST_DRAIN = 3'd2,
        ST_OUT   = 3'd3,
        ST_CLEAR = 3'd4
    } state_t;

    // One scan slot travelling down the cell chain.
    typedef struct packed {
        logic                 valid;
        logic                 eligible;
        logic [ADDR_BITS-1:0] addr;
    } slot_t;

endpackage

// ----- sv/npm_cell.sv -----
// One cell of the distance chain: squares one coordinate difference and adds
// it to the running sum handed in by the previous cell. Uses npm_pkg.
module npm_cell (
    input  logic                                  aclk,
    input  npm_pkg::slot_t                        slot_in,
    input  logic signed [npm_pkg::COORD_BITS-1:0] ref_coord,
    input  logic signed [npm_pkg::COORD_BITS-1:0] qry_coord,
    input  logic        [npm_pkg::SUM_BITS-1:0]   sum_in,
    output npm_pkg::slot_t                        slot_out,
    output logic        [npm_pkg::SUM_BITS-1:0]   sum_out
);
    logic signed [npm_pkg::DIFF_BITS-1:0] diff;
    logic        [npm_pkg::DIFF_BITS-1:0] mag;
    logic        [npm_pkg::SQ_BITS-1:0]   sq;
    npm_pkg::slot_t                       slot_reg;
    logic        [npm_pkg::SUM_BITS-1:0]  sum_reg;

    assign diff = npm_pkg::DIFF_BITS'(ref_coord) - npm_pkg::DIFF_BITS'(qry_coord);
    assign mag  = diff[npm_pkg::DIFF_BITS-1] ? npm_pkg::DIFF_BITS'(-diff)
                                             : npm_pkg::DIFF_BITS'(diff);
    assign sq   = mag * mag;

    always_ff @(posedge aclk) begin
        slot_reg <= slot_in;
        sum_reg  <= sum_in + npm_pkg::SUM_BITS'(sq);
    end

    assign slot_out = slot_reg;
    assign sum_out  = sum_reg;
endmodule

// ----- sv/npm_best.sv -----
// Best-candidate tracker at the end of the chain: saturates the distance,
// keeps the smallest one with ties to the later entry. Uses npm_pkg.
module npm_best (
    input  logic                             aclk,
    input  logic                             start,
    input  npm_pkg::slot_t                   slot_in,
    input  logic [npm_pkg::SUM_BITS-1:0]     sum_in,
    output logic                             found,
    output logic [npm_pkg::ADDR_BITS-1:0]    best_addr,
    output logic [npm_pkg::DIST_BITS-1:0]    best_dist
);
    logic                           found_reg, found_next;
    logic [npm_pkg::ADDR_BITS-1:0]  addr_reg, addr_next;
    logic [npm_pkg::DIST_BITS-1:0]  dist_reg, dist_next;
    logic [npm_pkg::DIST_BITS-1:0]  dist_sat;

    assign dist_sat = (sum_in > npm_pkg::SUM_BITS'(npm_pkg::DIST_SAT))
                      ? npm_pkg::DIST_SAT : npm_pkg::DIST_BITS'(sum_in);

    always_comb begin
        found_next = found_reg;
        addr_next  = addr_reg;
        dist_next  = dist_reg;
        if (start) begin
            found_next = 1'b0;
            addr_next  = '0;
            dist_next  = '0;
        end else if (slot_in.valid && slot_in.eligible &&
                     (!found_reg || dist_sat <= dist_reg)) begin
            found_next = 1'b1;
            addr_next  = slot_in.addr;
            dist_next  = dist_sat;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= found_next;
        addr_reg  <= addr_next;
        dist_reg  <= dist_next;
    end

    assign found     = found_reg;
    assign best_addr = addr_reg;
    assign best_dist = dist_reg;
endmodule

// ----- sv/nearest_point_matcher.sv -----
// Nearest point matcher. A query raises m_tvalid after a scan over n stored points, where
// n is ref_count capped at 1024: one point store read a cycle, then a chain of three
// distance cells and a best tracker. No new item is taken until the result has been taken.
// Load and unknown actions leave the block ready for the next item. A clear walks the used
// marks one entry a cycle. Reset (aresetn, synchronous) sets one_to_one = 1 and
// ref_count = 1024 and runs the same pass over the marks.
module nearest_point_matcher (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: action[1:0], point_index[11:2], coord_x[35:12], coord_y[59:36],
    // coord_z[83:60], zero fill [87:84]
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: match_index[9:0], match_sq_dist[59:10], found[60], zero fill [63:61]
    output logic [63:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [npm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0]  cfg_data
);
    localparam int CB = npm_pkg::COORD_BITS;
    localparam int AB = npm_pkg::ADDR_BITS;

    npm_pkg::state_t state_reg, state_next;
    logic                         one_to_one_reg;
    logic [npm_pkg::COUNT_BITS-1:0] ref_count_reg;
    logic                        used_mem [npm_pkg::MAX_POINTS];
    logic [AB-1:0]               clr_addr_reg;
    logic [CB-1:0]               qx_reg, qy_reg, qz_reg;
    logic [npm_pkg::COUNT_BITS-1:0] scan_cnt_reg, scan_lim_reg;
    logic [2:0]                  drain_reg;
    logic [npm_pkg::POINT_BITS-1:0] mem [npm_pkg::MAX_POINTS];
    logic [npm_pkg::POINT_BITS-1:0] rd_reg;
    logic [CB-1:0]               ry_d1_reg, rz_d1_reg, rz_d2_reg;
    npm_pkg::slot_t              rd_slot_reg, s1, s2, s3;
    logic [npm_pkg::SUM_BITS-1:0] sum1, sum2, sum3;
    logic                        found;
    logic [AB-1:0]               best_addr;
    logic [npm_pkg::DIST_BITS-1:0] best_dist;
    logic [63:0]                 out_reg;
    logic                        accept, start, clear_go, scan_go, mark_set;
    npm_pkg::action_t            act;
    logic [AB-1:0]               scan_addr;

    assign act       = npm_pkg::action_t'(s_tdata[1:0]);
    assign s_tready  = (state_reg == npm_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign start     = accept && act == npm_pkg::ACT_QUERY;
    assign clear_go  = accept && act == npm_pkg::ACT_CLEAR;
    assign cfg_ready = 1'b1;
    assign scan_go   = (state_reg == npm_pkg::ST_SCAN) && (scan_cnt_reg < scan_lim_reg);
    assign scan_addr = scan_cnt_reg[AB-1:0];
    assign mark_set  = (state_reg == npm_pkg::ST_DRAIN) && (drain_reg == 3'd5) && found;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            npm_pkg::ST_IDLE: begin
                if (start) state_next = npm_pkg::ST_SCAN;
                else if (clear_go) state_next = npm_pkg::ST_CLEAR;
            end
            npm_pkg::ST_SCAN:  if (!scan_go) state_next = npm_pkg::ST_DRAIN;
            npm_pkg::ST_DRAIN: if (drain_reg == 3'd5) state_next = npm_pkg::ST_OUT;
            npm_pkg::ST_OUT:   if (m_tready) state_next = npm_pkg::ST_IDLE;
            npm_pkg::ST_CLEAR: if (clr_addr_reg == AB'(npm_pkg::MAX_POINTS - 1))
                state_next = npm_pkg::ST_IDLE;
            default:           state_next = npm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid = (state_reg == npm_pkg::ST_OUT);
        m_tdata  = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= npm_pkg::ST_CLEAR;
            one_to_one_reg <= 1'b1;
            ref_count_reg  <= npm_pkg::COUNT_BITS'(npm_pkg::MAX_POINTS);
            clr_addr_reg   <= '0;
            rd_slot_reg    <= '0;
            drain_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (npm_pkg::cfg_reg_t'(cfg_index))
                    npm_pkg::CFG_ONE_TO_ONE: one_to_one_reg <= cfg_data[0];
                    npm_pkg::CFG_REF_COUNT:  ref_count_reg  <= cfg_data[10:0];
                    default: ;
                endcase
            end
            clr_addr_reg <= (state_reg == npm_pkg::ST_CLEAR) ? clr_addr_reg + 1'b1 : '0;
            rd_slot_reg.valid    <= scan_go;
            rd_slot_reg.eligible <= !(one_to_one_reg && used_mem[scan_addr]);
            rd_slot_reg.addr     <= scan_addr;
            drain_reg <= (state_reg == npm_pkg::ST_DRAIN) ? drain_reg + 3'd1 : 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            qx_reg       <= s_tdata[35:12];
            qy_reg       <= s_tdata[59:36];
            qz_reg       <= s_tdata[83:60];
            scan_cnt_reg <= '0;
            scan_lim_reg <= (ref_count_reg > npm_pkg::COUNT_BITS'(npm_pkg::MAX_POINTS))
                            ? npm_pkg::COUNT_BITS'(npm_pkg::MAX_POINTS) : ref_count_reg;
        end else if (scan_go) begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
        if (accept && act == npm_pkg::ACT_LOAD)
            mem[s_tdata[2+AB-1:2]] <= s_tdata[83:12];
        rd_reg <= mem[scan_addr];
        // The y and z coordinates follow their slot down the chain.
        ry_d1_reg <= rd_reg[2*CB-1:CB];
        rz_d1_reg <= rd_reg[3*CB-1:2*CB];
        rz_d2_reg <= rz_d1_reg;
        if (state_reg == npm_pkg::ST_CLEAR)
            used_mem[clr_addr_reg] <= 1'b0;
        else if (mark_set)
            used_mem[best_addr] <= 1'b1;
        if (state_reg == npm_pkg::ST_DRAIN && drain_reg == 3'd5)
            out_reg <= {3'b000, found, found ? best_dist : 50'd0,
                        found ? best_addr : {AB{1'b0}}};
    end

    npm_cell u_cell_x (.aclk(aclk), .slot_in(rd_slot_reg), .ref_coord(rd_reg[CB-1:0]),
        .qry_coord(qx_reg), .sum_in('0), .slot_out(s1), .sum_out(sum1));
    npm_cell u_cell_y (.aclk(aclk), .slot_in(s1), .ref_coord(ry_d1_reg),
        .qry_coord(qy_reg), .sum_in(sum1), .slot_out(s2), .sum_out(sum2));
    npm_cell u_cell_z (.aclk(aclk), .slot_in(s2), .ref_coord(rz_d2_reg),
        .qry_coord(qz_reg), .sum_in(sum2), .slot_out(s3), .sum_out(sum3));

    npm_best u_best (.aclk(aclk), .start(start), .slot_in(s3), .sum_in(sum3),
        .found(found), .best_addr(best_addr), .best_dist(best_dist));

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != npm_pkg::ST_IDLE) |-> !s_tready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped while stalled");
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_go |-> (scan_cnt_reg < npm_pkg::COUNT_BITS'(npm_pkg::MAX_POINTS)))
        else $error("scan beyond store");
`endif
endmodule
